@@ hdl/gnss_nav_chip_modulator_core_assert.svh @@
// ============================================================================
// GNSS navigation chip modulator assertion macros
// Concurrent assertion wrappers clocked by clk and disabled while rst_n is low.
// They expand to nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef GNSS_NAV_CHIP_MODULATOR_CORE_ASSERT_SVH
`define GNSS_NAV_CHIP_MODULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GNM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gnm assertion failed");
`define GNM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gnm assertion failed");
`else
`define GNM_ASSERT_IMP(label, ante, cons)
`define GNM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/gnm_pkg.sv @@
// ============================================================================
// GNSS navigation chip modulator package
// Shared widths, codes, amplitudes and divider handshake types.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package gnm_pkg;

    localparam int TIME_W     = 30;
    localparam int IDX_W      = 11;
    localparam int SAMPLE_W   = 16;
    localparam int FNUM_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = 6;
    localparam int NH_CHIPS   = 20;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_WR_BIT   = 2'd1,
        FUNC_WR_CHIP  = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIGNAL_MODE  = 3'd0,
        REG_CODE_LENGTH  = 3'd1,
        REG_NH_LENGTH    = 3'd2,
        REG_NH_PATTERN   = 3'd3,
        REG_FRAME_LENGTH = 3'd4,
        REG_SEC_LENGTH   = 3'd5,
        REG_LEAP_SECONDS = 3'd6,
        REG_SAT_ID       = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        MODE_L1CA = 4'd0,
        MODE_L1C  = 4'd1,
        MODE_L2C  = 4'd2,
        MODE_L5   = 4'd3,
        MODE_B1C  = 4'd4,
        MODE_B1I  = 4'd5,
        MODE_B2A  = 4'd6,
        MODE_B2B  = 4'd7,
        MODE_E1   = 4'd8,
        MODE_E5A  = 4'd9,
        MODE_E5B  = 4'd10,
        MODE_E6   = 4'd11,
        MODE_G1G2 = 4'd12
    } mode_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD_DAY,
        S_PREP,
        S_FRAME,
        S_BIT,
        S_ROUND,
        S_SEC_DIV,
        S_SEC_MOD,
        S_READ,
        S_OUT
    } state_t;

    localparam logic [TIME_W-1:0] BDS_SHIFT_MS  = 30'd14000;
    localparam logic [TIME_W-1:0] BDS_WRAP_MS   = 30'd604786000;
    localparam logic [TIME_W:0]   GLO_SHIFT_MS  = 31'd10800000;
    localparam logic [TIME_W:0]   E1_BIAS_MS    = 31'd1000;
    localparam logic [15:0]       MS_PER_SECOND = 16'd1000;
    localparam logic [DIV_W-1:0]  DAY_MS        = 32'd86400000;

    localparam logic signed [SAMPLE_W-1:0] AMP_FULL_POS   = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] AMP_FULL_NEG   = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] AMP_HALF       = 16'sd16384;
    localparam logic signed [SAMPLE_W-1:0] AMP_HALF_POWER = 16'sd23170;
    localparam logic signed [SAMPLE_W-1:0] AMP_PILOT_BIG  = 16'sd26603;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] bits;
        logic [DIV_W-1:0]     dividend;
        logic [DIV_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/gnm_req_if.sv @@
// ============================================================================
// GNSS navigation chip modulator request channel
// Valid/ready channel carrying time ticks and store writes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface gnm_req_if;
    import gnm_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [TIME_W-1:0]   time_ms;
    logic [IDX_W-1:0]    store_index;
    logic                store_value;

    modport source (output valid, func, time_ms, store_index, store_value, input ready);
    modport sink   (input valid, func, time_ms, store_index, store_value, output ready);
endinterface

`default_nettype wire

@@ hdl/gnm_rsp_if.sv @@
// ============================================================================
// GNSS navigation chip modulator response channel
// Valid/ready channel carrying one modulated result word per tick.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface gnm_rsp_if;
    import gnm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] data_i;
    logic signed [SAMPLE_W-1:0] data_q;
    logic signed [SAMPLE_W-1:0] pilot_i;
    logic signed [SAMPLE_W-1:0] pilot_q;
    logic                       new_frame;
    logic [FNUM_W-1:0]          frame_number;
    logic                       ok;

    modport source (output valid, data_i, data_q, pilot_i, pilot_q, new_frame, frame_number,
                    ok, input ready);
    modport sink   (input valid, data_i, data_q, pilot_i, pilot_q, new_frame, frame_number,
                    ok, output ready);
endinterface

`default_nettype wire

@@ hdl/gnm_chip_ram.sv @@
// ============================================================================
// GNSS navigation chip modulator one-bit RAM
// Single write port and one registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module gnm_chip_ram #(
    parameter int DEPTH = 2048
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic                     wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic                     rdata
);
    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

@@ hdl/gnm_serial_div.sv @@
// ============================================================================
// GNSS navigation chip modulator serial divider
// Restoring divider that takes one dividend bit per cycle, MSB first.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "gnss_nav_chip_modulator_core_assert.svh"

module gnm_serial_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  gnm_pkg::div_req_t req,
    output gnm_pkg::div_rsp_t rsp
);
    import gnm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.bits;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `GNM_ASSERT_IMP(a_start_when_free, req.start, !busy_reg)
    `GNM_ASSERT_NEXT(a_start_runs, req.start, busy_reg && !done_reg)
    `GNM_ASSERT_IMP(a_rem_below_divisor, done_reg, !busy_reg && (rem_reg < dsr_reg))
endmodule

`default_nettype wire

@@ hdl/gnss_nav_chip_modulator_core.sv @@
// ============================================================================
// GNSS navigation chip modulator
// Time shift, frame/bit/round split and data and pilot chip scaling per tick.
// ============================================================================
//
// Channel   Dir  Handshake          Word
// req       in   valid/ready        func, time_ms, store_index, store_value
// rsp       out  valid/ready        data_i, data_q, pilot_i, pilot_q, new_frame,
//                                   frame_number, ok
// cfg       in   cfg_we only        cfg_addr, cfg_wdata
//
// A tick runs through the serial divider, one bit per cycle, in this order: the
// GLONASS day wrap (G1G2 mode only), the frame split, the bit index, the code
// round and the pilot position (only when a secondary length is set); a tick
// with satellite id zero or an unknown mode skips the divider. After reset every
// address of the navigation bit store is cleared, with req.ready low. A finished
// word waits in the output register while the next word is accepted and
// processed; a second finished word holds req.ready low.
//
`timescale 1ns / 1ps
`default_nettype none
`include "gnss_nav_chip_modulator_core_assert.svh"

module gnss_nav_chip_modulator_core #(
    parameter int NAV_BIT_DEPTH   = 2048,
    parameter int SECONDARY_DEPTH = 2048
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    gnm_req_if.sink                          req,
    gnm_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [gnm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [gnm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import gnm_pkg::*;

    localparam int NAV_AW = $clog2(NAV_BIT_DEPTH);
    localparam int SEC_AW = $clog2(SECONDARY_DEPTH);

    state_t                     state_reg, state_next;
    logic [NAV_AW-1:0]          clr_cnt_reg;

    logic [3:0]                 mode_reg;
    logic [4:0]                 code_len_reg;
    logic [4:0]                 nh_len_reg;
    logic [19:0]                nh_pat_reg;
    logic [14:0]                frame_len_reg;
    logic [11:0]                sec_len_reg;
    logic [5:0]                 leap_reg;
    logic [5:0]                 sat_reg;

    logic [TIME_W-1:0]          t_reg;
    logic [FNUM_W-1:0]          fnum_reg;
    logic                       nf_reg;
    logic                       conf_reg;
    logic [14:0]                bitnum_reg;
    logic [4:0]                 round_reg;
    logic [SEC_AW-1:0]          pos_reg;
    logic [FNUM_W-1:0]          last_frame_reg;
    logic                       frame_seen_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] data_i_reg;
    logic signed [SAMPLE_W-1:0] data_q_reg;
    logic signed [SAMPLE_W-1:0] pilot_i_reg;
    logic                       new_frame_reg;
    logic [FNUM_W-1:0]          frame_number_reg;
    logic                       ok_reg;

    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    logic [4:0]                 code_eff;
    logic [4:0]                 nh_eff;
    logic [14:0]                flen_eff;
    logic [9:0]                 bitlen;
    logic [DIV_W-1:0]           slen;
    logic                       pilot_on;
    logic                       unconf;
    logic                       accept;
    logic                       tick_acc;
    logic                       bit_wr;
    logic                       chip_wr;
    logic [15:0]                leap_ms;
    logic [TIME_W:0]            glo_x;
    logic [TIME_W-1:0]          t_shift;
    logic [TIME_W:0]            ms;
    logic                       load_out;
    logic [FNUM_W-1:0]          quo_frame;

    logic                       nav_we;
    logic [NAV_AW-1:0]          nav_waddr;
    logic                       nav_wdata;
    logic                       nav_rdata;
    logic                       sec_rdata;
    logic                       nav_bit;
    logic [19:0]                nh_shift;
    logic                       nh_chip;
    logic                       d_neg;
    logic signed [SAMPLE_W-1:0] di;
    logic signed [SAMPLE_W-1:0] dq;
    logic signed [SAMPLE_W-1:0] pi;

    function automatic logic signed [SAMPLE_W-1:0] signed_amp(
        input logic                       neg,
        input logic signed [SAMPLE_W-1:0] amp
    );
        signed_amp = neg ? -amp : amp;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pilot_amp(
        input logic                       on,
        input logic                       neg,
        input logic signed [SAMPLE_W-1:0] amp
    );
        pilot_amp = on ? signed_amp(neg, amp) : '0;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_L1CA;
            code_len_reg  <= 5'd1;
            nh_len_reg    <= 5'd20;
            nh_pat_reg    <= '0;
            frame_len_reg <= 15'd6000;
            sec_len_reg   <= '0;
            leap_reg      <= 6'd18;
            sat_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_SIGNAL_MODE:  mode_reg      <= cfg_wdata[3:0];
                REG_CODE_LENGTH:  code_len_reg  <= cfg_wdata[4:0];
                REG_NH_LENGTH:    nh_len_reg    <= cfg_wdata[4:0];
                REG_NH_PATTERN:   nh_pat_reg    <= cfg_wdata[19:0];
                REG_FRAME_LENGTH: frame_len_reg <= cfg_wdata[14:0];
                REG_SEC_LENGTH:   sec_len_reg   <= cfg_wdata[11:0];
                REG_LEAP_SECONDS: leap_reg      <= cfg_wdata[5:0];
                REG_SAT_ID:       sat_reg       <= cfg_wdata[5:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        code_eff = (code_len_reg == '0) ? 5'd1 : code_len_reg;
        nh_eff   = (nh_len_reg == '0) ? 5'd1 : nh_len_reg;
        flen_eff = (frame_len_reg == '0) ? 15'd1 : frame_len_reg;
        bitlen   = {5'd0, code_eff} * {5'd0, nh_eff};
        slen     = (DIV_W'(sec_len_reg) > DIV_W'(SECONDARY_DEPTH)) ?
                   DIV_W'(SECONDARY_DEPTH) : DIV_W'(sec_len_reg);
        pilot_on = (sec_len_reg != '0);
        unconf   = (sat_reg == '0) || (mode_reg > MODE_G1G2);

        accept   = req.valid && req.ready;
        tick_acc = accept && (func_t'(req.func) == FUNC_TICK);
        bit_wr   = accept && (func_t'(req.func) == FUNC_WR_BIT) &&
                   (DIV_W'(req.store_index) < DIV_W'(NAV_BIT_DEPTH));
        chip_wr  = accept && (func_t'(req.func) == FUNC_WR_CHIP) &&
                   (DIV_W'(req.store_index) < DIV_W'(SECONDARY_DEPTH));

        leap_ms  = {10'd0, leap_reg} * MS_PER_SECOND;
        glo_x    = {1'b0, req.time_ms} + GLO_SHIFT_MS - (TIME_W+1)'(leap_ms);
        if ((mode_reg >= MODE_B1C) && (mode_reg <= MODE_B2B))
        begin
            t_shift = (req.time_ms < BDS_SHIFT_MS) ? req.time_ms + BDS_WRAP_MS
                                                    : req.time_ms - BDS_SHIFT_MS;
        end
        else
        begin
            t_shift = req.time_ms;
        end
        ms        = {1'b0, t_reg} + ((mode_reg == MODE_E1) ? E1_BIAS_MS : '0);
        quo_frame = div_rsp.quotient[FNUM_W-1:0];
        load_out  = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);
    end

    // Sequencer for one tick through the shared divider.
    always_comb
    begin
        state_next = state_reg;
        div_req    = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == NAV_AW'(NAV_BIT_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (tick_acc)
                begin
                    if (unconf)
                    begin
                        state_next = S_OUT;
                    end
                    else if (mode_reg == MODE_G1G2)
                    begin
                        div_req.start    = 1'b1;
                        div_req.bits     = DIV_CNT_W'(TIME_W + 1);
                        div_req.dividend = DIV_W'(glo_x) << (DIV_W - TIME_W - 1);
                        div_req.divisor  = DAY_MS;
                        state_next       = S_MOD_DAY;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_MOD_DAY:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                div_req.start    = 1'b1;
                div_req.bits     = DIV_CNT_W'(TIME_W + 1);
                div_req.dividend = DIV_W'(ms) << (DIV_W - TIME_W - 1);
                div_req.divisor  = DIV_W'(flen_eff);
                state_next       = S_FRAME;
            end
            S_FRAME:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.bits     = DIV_CNT_W'(15);
                    div_req.dividend = DIV_W'(div_rsp.remainder[14:0]) << (DIV_W - 15);
                    div_req.divisor  = DIV_W'(bitlen);
                    state_next       = S_BIT;
                end
            end
            S_BIT:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.bits     = DIV_CNT_W'(10);
                    div_req.dividend = DIV_W'(div_rsp.remainder[9:0]) << (DIV_W - 10);
                    div_req.divisor  = DIV_W'(code_eff);
                    state_next       = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (div_rsp.done)
                begin
                    if (pilot_on)
                    begin
                        div_req.start    = 1'b1;
                        div_req.bits     = DIV_CNT_W'(TIME_W);
                        div_req.dividend = DIV_W'(t_reg) << (DIV_W - TIME_W);
                        div_req.divisor  = DIV_W'(code_eff);
                        state_next       = S_SEC_DIV;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_SEC_DIV:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.bits     = DIV_CNT_W'(TIME_W);
                    div_req.dividend = DIV_W'(div_rsp.quotient[TIME_W-1:0]) << (DIV_W - TIME_W);
                    div_req.divisor  = slen;
                    state_next       = S_SEC_MOD;
                end
            end
            S_SEC_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            last_frame_reg <= '0;
            frame_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if ((state_reg == S_FRAME) && div_rsp.done)
            begin
                last_frame_reg <= quo_frame;
                frame_seen_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            t_reg    <= t_shift;
            conf_reg <= !unconf;
        end
        if ((state_reg == S_MOD_DAY) && div_rsp.done)
        begin
            t_reg <= div_rsp.remainder[TIME_W-1:0];
        end
        if ((state_reg == S_FRAME) && div_rsp.done)
        begin
            fnum_reg <= quo_frame;
            nf_reg   <= !frame_seen_reg || (quo_frame != last_frame_reg);
        end
        if ((state_reg == S_BIT) && div_rsp.done)
        begin
            bitnum_reg <= div_rsp.quotient[14:0];
        end
        if ((state_reg == S_ROUND) && div_rsp.done)
        begin
            round_reg <= div_rsp.quotient[4:0];
        end
        if ((state_reg == S_SEC_MOD) && div_rsp.done)
        begin
            pos_reg <= div_rsp.remainder[SEC_AW-1:0];
        end
        if (load_out)
        begin
            data_i_reg       <= conf_reg ? di : '0;
            data_q_reg       <= conf_reg ? dq : '0;
            pilot_i_reg      <= conf_reg ? pi : '0;
            new_frame_reg    <= conf_reg && nf_reg;
            frame_number_reg <= conf_reg ? fnum_reg : '0;
            ok_reg           <= conf_reg;
        end
    end

    gnm_serial_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The clearing pass shares the write port with host writes.
    always_comb
    begin
        nav_we    = (state_reg == S_CLEAR) || bit_wr;
        nav_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : NAV_AW'(req.store_index);
        nav_wdata = (state_reg == S_CLEAR) ? 1'b0 : req.store_value;
    end

    gnm_chip_ram #(
        .DEPTH (NAV_BIT_DEPTH)
    ) u_nav_ram
    (
        .clk   (clk),
        .we    (nav_we),
        .waddr (nav_waddr),
        .wdata (nav_wdata),
        .re    (state_reg == S_READ),
        .raddr (NAV_AW'(bitnum_reg)),
        .rdata (nav_rdata)
    );

    gnm_chip_ram #(
        .DEPTH (SECONDARY_DEPTH)
    ) u_sec_ram
    (
        .clk   (clk),
        .we    (chip_wr),
        .waddr (SEC_AW'(req.store_index)),
        .wdata (req.store_value),
        .re    (state_reg == S_READ),
        .raddr (pos_reg),
        .rdata (sec_rdata)
    );

    // Bit indexes past the store read as a zero bit.
    always_comb
    begin
        nav_bit  = (DIV_W'(bitnum_reg) < DIV_W'(NAV_BIT_DEPTH)) && nav_rdata;
        nh_shift = nh_pat_reg >> round_reg;
        nh_chip  = (round_reg < 5'(NH_CHIPS)) && nh_shift[0];
        d_neg    = nav_bit ^ nh_chip;
        di       = '0;
        dq       = '0;
        pi       = '0;
        case (mode_reg)
            MODE_L1CA, MODE_B1I, MODE_G1G2:
            begin
                di = d_neg ? AMP_FULL_NEG : AMP_FULL_POS;
            end
            MODE_L1C:
            begin
                di = signed_amp(d_neg, AMP_HALF);
                pi = pilot_amp(pilot_on, sec_rdata, AMP_PILOT_BIG);
            end
            MODE_L2C:
            begin
                di = signed_amp(d_neg, AMP_HALF_POWER);
                pi = AMP_HALF_POWER;
            end
            MODE_L5:
            begin
                dq = signed_amp(d_neg, AMP_HALF_POWER);
                pi = pilot_amp(pilot_on, sec_rdata, AMP_HALF_POWER);
            end
            MODE_B1C:
            begin
                dq = signed_amp(!d_neg, AMP_HALF);
                pi = pilot_amp(pilot_on, sec_rdata, AMP_PILOT_BIG);
            end
            MODE_B2A, MODE_E5A, MODE_E5B:
            begin
                dq = signed_amp(!d_neg, AMP_HALF_POWER);
                pi = pilot_amp(pilot_on, sec_rdata, AMP_HALF_POWER);
            end
            MODE_B2B:
            begin
                dq = signed_amp(!d_neg, AMP_HALF_POWER);
            end
            MODE_E1:
            begin
                di = signed_amp(!d_neg, AMP_HALF_POWER);
                pi = pilot_amp(pilot_on, sec_rdata, AMP_HALF_POWER);
            end
            MODE_E6:
            begin
                pi = pilot_amp(pilot_on, sec_rdata, AMP_HALF_POWER);
            end
            default:
            begin
                di = '0;
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.data_i       = data_i_reg;
    assign rsp.data_q       = data_q_reg;
    assign rsp.pilot_i      = pilot_i_reg;
    assign rsp.pilot_q      = '0;
    assign rsp.new_frame    = new_frame_reg;
    assign rsp.frame_number = frame_number_reg;
    assign rsp.ok           = ok_reg;

    `GNM_ASSERT_IMP(a_ok_has_frame, out_valid_reg && ok_reg, frame_seen_reg)
    `GNM_ASSERT_IMP(a_nav_write_free, nav_we, state_reg == S_CLEAR || state_reg == S_IDLE)
    `GNM_ASSERT_IMP(a_unconf_zero, out_valid_reg && !ok_reg,
                    data_i_reg == '0 && pilot_i_reg == '0 && frame_number_reg == '0)
    `GNM_ASSERT_IMP(a_no_div_in_idle, state_reg == S_IDLE, !div_rsp.done)
endmodule

`default_nettype wire
